FILE: hw/rtl/gdfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdfw_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int CMD_W   = 2;
  localparam int VTX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SDATA_W = 16;
  localparam int MDATA_W = 8;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_WALK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ERR,
    ST_POP,
    ST_POP_WAIT,
    ST_HEAD,
    ST_NODE,
    ST_FLUSH
  } state_t;

  // Control of the list head table.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } head_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gdfw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port synchronous RAM, one write and one registered read port.
module gdfw_ram #(
  parameter int DEPTH = 256,
  parameter int DW    = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gdfw_head_table.sv
`timescale 1ns / 1ps
`default_nettype none

// List head memory with one valid bit per vertex; an entry that is not valid
// reads as the null link. Clearing drops all valid bits at once.
module gdfw_head_table
  import gdfw_pkg::*;
#(
  parameter int VERTS  = 64,
  parameter int LINK_W = 9,
  localparam int VW    = $clog2(VERTS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire head_ctl_t         ctl,
  input  wire logic [VW-1:0]     raddr,
  input  wire logic [VW-1:0]     waddr,
  input  wire logic [LINK_W-1:0] wdata,
  input  wire logic [LINK_W-1:0] null_link,
  output logic      [LINK_W-1:0] link
);

  logic [LINK_W-1:0] mem [VERTS];
  logic [VERTS-1:0]  valid;
  logic [LINK_W-1:0] rdata;
  logic              rvalid;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (ctl.rd) begin
      rvalid <= valid[raddr];
    end
  end

  assign link = rvalid ? rdata : null_link;

endmodule

`default_nettype wire

FILE: hw/rtl/graph_depth_first_walk_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Depth-first walk unit over an undirected graph kept as adjacency lists.
// Input items arrive on the s_ stream: s_tuser carries the command (add
// edge, traverse, clear) and s_tdata the two vertex numbers. Traverse items
// give one output transaction per visited vertex on the m_ stream in visit
// order, the final one with m_tlast high; a start vertex outside the active
// count gives a single transaction with m_tuser high, vertex 0 and m_tlast.
// The vertex count register is to be written through the cfg_ channel only
// while idle; the block itself does not enforce this. An add-edge item
// does one list head read, then one node write per endpoint. A clear or an
// ignored item is handled in the cycle in which it is accepted. A traversal
// works through stack pops, a head read per newly visited vertex and one
// step per list node walked, so its length follows the number of stored
// edges.
// Reset empties all lists at once through per-vertex valid bits, so no
// clearing pass is needed and items are taken from the first cycle after.
// One result waits in the output register; when the receiver stalls the
// walk halts at the next visited vertex until the register frees up.
module graph_depth_first_walk_unit
  import gdfw_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [SDATA_W-1:0] s_tdata,   // vertex_a [5:0], vertex_b [11:6], zero
  input  wire logic [CMD_W-1:0]   s_tuser,   // cmd [1:0]
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [MDATA_W-1:0] m_tdata,   // vertex [5:0], zero
  output logic                    m_tlast,
  output logic                    m_tuser,   // error [0]
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CNT_W-1:0]   cfg_data
);

  localparam int NODE_COUNT = 2 * MAX_EDGES;
  localparam int STACK_SIZE = NODE_COUNT + 1;
  localparam int VW         = $clog2(MAX_VERTICES);
  localparam int LINK_W     = $clog2(NODE_COUNT + 1);
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int STACK_AW   = $clog2(STACK_SIZE);
  localparam int DEPTH_W    = $clog2(STACK_SIZE + 1);
  localparam int NODE_DW    = VW + LINK_W;

  localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(NODE_COUNT);
  localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_VERTICES);
  localparam logic [DEPTH_W-1:0] STK_FULL  = DEPTH_W'(STACK_SIZE);

  state_t state, state_next;

  // Registers.
  logic [CNT_W-1:0]        vertex_count;
  logic [VW-1:0]           op_a, op_b;
  logic [LINK_W-1:0]       used, used_next;
  logic [DEPTH_W-1:0]      depth, depth_next;
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [VW-1:0]           pend, pend_next;
  logic                    pend_valid, pend_valid_next;
  logic [VTX_W-1:0]        out_vtx, out_vtx_next;
  logic                    out_last, out_last_next;
  logic                    out_err, out_err_next;
  logic                    out_load;

  // Memory ports.
  head_ctl_t               head_ctl;
  logic [VW-1:0]           head_raddr, head_waddr;
  logic [LINK_W-1:0]       head_wdata, head_link;
  logic                    node_we, node_re;
  logic [NODE_AW-1:0]      node_waddr, node_raddr;
  logic [NODE_DW-1:0]      node_wdata, node_rdata;
  logic                    stk_we, stk_re;
  logic [STACK_AW-1:0]     stk_waddr, stk_raddr;
  logic [VW-1:0]           stk_wdata, stk_rdata;

  // Decoded input item and helpers.
  cmd_t                    in_cmd;
  logic [VTX_W-1:0]        in_a, in_b;
  logic [CNT_W-1:0]        act_cnt;
  logic                    accept, add_ok, walk_ok, out_free;
  logic [LINK_W-1:0]       used_inc, link_b;
  logic [LINK_W:0]         used_room;
  logic [DEPTH_W-1:0]      depth_dec;
  logic [VW-1:0]           node_w;
  logic [LINK_W-1:0]       node_nx;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_a      = s_tdata[VTX_W-1:0];
  assign in_b      = s_tdata[2*VTX_W-1:VTX_W];
  assign act_cnt   = (vertex_count > MAX_CNT) ? MAX_CNT : vertex_count;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign used_room = {1'b0, used} + (LINK_W+1)'(2);
  assign add_ok    = ({1'b0, in_a} < act_cnt) && ({1'b0, in_b} < act_cnt) &&
                     (used_room <= (LINK_W+1)'(NODE_COUNT));
  assign walk_ok   = ({1'b0, in_a} < act_cnt);
  assign used_inc  = used + LINK_W'(1);
  assign depth_dec = depth - DEPTH_W'(1);
  assign node_w    = node_rdata[NODE_DW-1:LINK_W];
  assign node_nx   = node_rdata[LINK_W-1:0];
  // A self loop reads the head that the first prepend has just replaced.
  assign link_b    = (op_a == op_b) ? used : head_link;

  gdfw_head_table #(
    .VERTS  (MAX_VERTICES),
    .LINK_W (LINK_W)
  ) u_head (
    .clk       (clk),
    .rst       (rst),
    .ctl       (head_ctl),
    .raddr     (head_raddr),
    .waddr     (head_waddr),
    .wdata     (head_wdata),
    .null_link (NULL_LINK),
    .link      (head_link)
  );

  gdfw_ram #(
    .DEPTH (NODE_COUNT),
    .DW    (NODE_DW)
  ) u_nodes (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  gdfw_ram #(
    .DEPTH (STACK_SIZE),
    .DW    (VW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ADD:  state_next = add_ok ? ST_ADD_A : ST_IDLE;
            CMD_WALK: state_next = walk_ok ? ST_POP : ST_ERR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A: state_next = ST_ADD_B;
      ST_ADD_B: state_next = ST_IDLE;
      ST_ERR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: state_next = (depth == '0) ? ST_FLUSH : ST_POP_WAIT;
      ST_POP_WAIT: begin
        if (visited[stk_rdata]) begin
          state_next = ST_POP;
        end else if (!pend_valid || out_free) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: state_next = (head_link == NULL_LINK) ? ST_POP : ST_NODE;
      ST_NODE: state_next = (node_nx == NULL_LINK) ? ST_POP : ST_NODE;
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and register next values.
  always_comb begin
    head_ctl        = '0;
    head_raddr      = op_a;
    head_waddr      = op_a;
    head_wdata      = used;
    node_we         = 1'b0;
    node_waddr      = used[NODE_AW-1:0];
    node_wdata      = {op_b, head_link};
    node_re         = 1'b0;
    node_raddr      = head_link[NODE_AW-1:0];
    stk_we          = 1'b0;
    stk_waddr       = depth[STACK_AW-1:0];
    stk_wdata       = node_w;
    stk_re          = 1'b0;
    stk_raddr       = depth_dec[STACK_AW-1:0];
    used_next       = used;
    depth_next      = depth;
    visited_next    = visited;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_load        = 1'b0;
    out_vtx_next    = VTX_W'(pend);
    out_last_next   = 1'b0;
    out_err_next    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ADD: begin
              head_ctl.rd = add_ok;
              head_raddr  = in_a[VW-1:0];
            end
            CMD_WALK: begin
              if (walk_ok) begin
                visited_next    = '0;
                pend_valid_next = 1'b0;
                stk_we          = 1'b1;
                stk_waddr       = '0;
                stk_wdata       = in_a[VW-1:0];
                depth_next      = DEPTH_W'(1);
              end
            end
            CMD_CLEAR: begin
              head_ctl.clr = 1'b1;
              used_next    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_A: begin
        node_we     = 1'b1;
        head_ctl.wr = 1'b1;
        head_ctl.rd = 1'b1;
        head_raddr  = op_b;
      end
      ST_ADD_B: begin
        node_we     = 1'b1;
        node_waddr  = used_inc[NODE_AW-1:0];
        node_wdata  = {op_a, link_b};
        head_ctl.wr = 1'b1;
        head_waddr  = op_b;
        head_wdata  = used_inc;
        used_next   = used + LINK_W'(2);
      end
      ST_ERR: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_vtx_next  = '0;
          out_last_next = 1'b1;
          out_err_next  = 1'b1;
        end
      end
      ST_POP: begin
        if (depth != '0) begin
          stk_re     = 1'b1;
          depth_next = depth_dec;
        end
      end
      ST_POP_WAIT: begin
        if (!visited[stk_rdata] && (!pend_valid || out_free)) begin
          visited_next[stk_rdata] = 1'b1;
          out_load        = pend_valid;
          pend_next       = stk_rdata;
          pend_valid_next = 1'b1;
          head_ctl.rd     = 1'b1;
          head_raddr      = stk_rdata;
        end
      end
      ST_HEAD: begin
        node_re = (head_link != NULL_LINK);
      end
      ST_NODE: begin
        if (!visited[node_w] && (depth < STK_FULL)) begin
          stk_we     = 1'b1;
          depth_next = depth + DEPTH_W'(1);
        end
        node_re    = (node_nx != NULL_LINK);
        node_raddr = node_nx[NODE_AW-1:0];
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= COUNT_RESET;
      used         <= '0;
      depth        <= '0;
      visited      <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state      <= state_next;
      used       <= used_next;
      depth      <= depth_next;
      visited    <= visited_next;
      pend_valid <= pend_valid_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_a <= in_a[VW-1:0];
      op_b <= in_b[VW-1:0];
    end
    pend <= pend_next;
    if (out_load) begin
      out_vtx  <= out_vtx_next;
      out_last <= out_last_next;
      out_err  <= out_err_next;
    end
  end

  assign m_tdata = MDATA_W'(out_vtx);
  assign m_tlast = out_last;
  assign m_tuser = out_err;

  // An error result always closes its transaction run.
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> m_tlast)
    else $error("error result without last flag");

  // The node store never hands out more nodes than it holds.
  assert property (@(posedge clk) disable iff (rst) used <= LINK_W'(NODE_COUNT))
    else $error("node allocation beyond memory size");

  // Every traversal still holds a pending visited vertex when it is closed.
  assert property (@(posedge clk) disable iff (rst) (state == ST_FLUSH) |-> pend_valid)
    else $error("traversal closed with no pending vertex");

  // A result is never overwritten while the receiver still stalls it.
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: dv/graph_depth_first_walk_unit_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the walk unit, keeps its own copy of the
// graph and the vertex count, and compares every output transaction with
// the oldest visit still owed.
module graph_depth_first_walk_unit_checker
  import gdfw_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,   // vertex_a [5:0], vertex_b [11:6], zero
  input  logic [CMD_W-1:0]   s_tuser,   // cmd [1:0]
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [MDATA_W-1:0] m_tdata,   // vertex [5:0], zero
  input  logic               m_tlast,
  input  logic               m_tuser,   // error [0]
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data,
  output int                 mismatch_count,
  output int                 visits_owed
);

  localparam int NODES       = 2 * MAX_EDGES;
  localparam int STACK_LIMIT = NODES + 1;
  localparam int NO_LINK     = NODES;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
    logic             error;
  } visit_t;

  int     vertex_limit;
  int     adj_head [MAX_VERTICES];
  int     adj_vertex [NODES];
  int     adj_link [NODES];
  int     nodes_taken;
  visit_t visits_due [$];

  task automatic empty_graph();
    for (int i = 0; i < MAX_VERTICES; i++) adj_head[i] = NO_LINK;
    nodes_taken = 0;
  endtask

  task automatic link_node(input int owner, input int other);
    adj_vertex[nodes_taken] = other;
    adj_link[nodes_taken]   = adj_head[owner];
    adj_head[owner]         = nodes_taken;
    nodes_taken++;
  endtask

  // Iterative depth-first walk; neighbours are pushed in list order, so the
  // newest edge of a vertex is explored last.
  task automatic walk_from(input int start);
    bit     seen [MAX_VERTICES];
    int     pending [$];
    int     order [$];
    int     v;
    int     w;
    int     ln;
    visit_t r;
    for (int i = 0; i < MAX_VERTICES; i++) seen[i] = 1'b0;
    pending.push_back(start);
    while (pending.size() > 0) begin
      v = pending.pop_back() % MAX_VERTICES;
      if (seen[v]) continue;
      seen[v] = 1'b1;
      if (order.size() < MAX_VERTICES) order.push_back(v);
      ln = adj_head[v];
      while (ln < NODES) begin
        w = adj_vertex[ln] % MAX_VERTICES;
        if (!seen[w] && pending.size() < STACK_LIMIT) pending.push_back(w);
        ln = adj_link[ln];
      end
    end
    for (int i = 0; i < order.size(); i++) begin
      r.vertex = order[i];
      r.last   = (i == order.size() - 1);
      r.error  = 1'b0;
      visits_due.push_back(r);
    end
  endtask

  task automatic take_item(input logic [CMD_W-1:0] op, input int a, input int b);
    int     lim;
    visit_t r;
    lim = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    case (op)
      CMD_ADD: begin
        if (a < lim && b < lim && nodes_taken + 2 <= NODES) begin
          link_node(a, b);
          link_node(b, a);
        end
      end
      CMD_WALK: begin
        if (a >= lim) begin
          r.vertex = '0;
          r.last   = 1'b1;
          r.error  = 1'b1;
          visits_due.push_back(r);
        end else begin
          walk_from(a);
        end
      end
      CMD_CLEAR: begin
        empty_graph();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    visit_t want;
    if (rst) begin
      vertex_limit = COUNT_RESET;
      mismatch_count = 0;
      empty_graph();
      visits_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) vertex_limit = cfg_data;
      if (s_tvalid && s_tready)
        take_item(s_tuser, s_tdata[VTX_W-1:0], s_tdata[2*VTX_W-1:VTX_W]);
      if (m_tvalid && m_tready) begin
        if (visits_due.size() == 0) begin
          $error("unexpected output transaction: vertex %0d, last %0d, error %0d",
                 m_tdata[VTX_W-1:0], m_tlast, m_tuser);
          mismatch_count++;
        end else begin
          want = visits_due.pop_front();
          if (m_tdata[VTX_W-1:0] !== want.vertex) begin
            $error("vertex mismatch: expected %0d, actual %0d",
                   want.vertex, m_tdata[VTX_W-1:0]);
            mismatch_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
            mismatch_count++;
          end
          if (m_tuser !== want.error) begin
            $error("error mismatch: expected %0d, actual %0d", want.error, m_tuser);
            mismatch_count++;
          end
        end
      end
    end
    visits_owed <= visits_due.size();
  end

endmodule

FILE: dv/graph_depth_first_walk_unit_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the depth-first walk unit. The checker beside
// the block does all prediction and comparison; this module only creates
// transactions, changes the vertex count between phases and reports the
// outcome.
module graph_depth_first_walk_unit_test;
  import gdfw_pkg::*;

  // The fourth command code is unused by the block and must be ignored.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // Cycles allowed after the last result for an add edge still in flight.
  localparam int SETTLE_CYCLES = 8;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata   = '0;   // vertex_a [5:0], vertex_b [11:6], zero
  logic [CMD_W-1:0]   s_tuser   = CMD_ADD;  // cmd [1:0]
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [MDATA_W-1:0] m_tdata;          // vertex [5:0], zero
  logic               m_tlast;
  logic               m_tuser;          // error [0]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data  = COUNT_RESET;

  int mismatch_count;
  int visits_owed;
  int lim;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  always #4 clk = ~clk;

  graph_depth_first_walk_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  graph_depth_first_walk_unit_checker walk_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .visits_owed    (visits_owed)
  );

  // The receiver refuses a transaction with a chance of roughly 17 in a
  // hundred, except while the steady stretch is running.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 17);
  end

  // Offers one input transaction, possibly after some idle cycles, and
  // returns at the edge at which it is accepted. The valid is left high so
  // that a following item can be offered back to back.
  task automatic send_item(input logic [CMD_W-1:0] op, input int a, input int b);
    while (!steady && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, b[VTX_W-1:0], a[VTX_W-1:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every owed visit has arrived, then gives any trailing add
  // edge time to finish its node writes.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (visits_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lim = (value > 64) ? 64 : value;
  endtask

  // Picks a vertex inside the active range, or anywhere when no vertex
  // is in use.
  function automatic int pick_vertex();
    return (lim == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
  endfunction

  // A phase of random items: mostly edges and walks that stay inside the
  // active range, with clears, unused commands and out-of-range noise mixed in.
  task automatic random_phase(input int count_value, input int items);
    int roll;
    set_vertex_count(count_value);
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)
        send_item(CMD_ADD, pick_vertex(), pick_vertex());
      else if (roll < 80)
        send_item(CMD_WALK, pick_vertex(), $urandom_range(0, 63));
      else if (roll < 85)
        send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
      else if (roll < 90)
        send_item(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63));
      else
        send_item($urandom_range(0, 1) ? CMD_WALK : CMD_ADD,
                  $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  initial begin
    lim = 64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count: a walk over an empty graph, the extreme vertices, a
    // self loop, the unused command and a clear followed by a walk.
    send_item(CMD_WALK, 0, 0);
    send_item(CMD_ADD, 0, 63);
    send_item(CMD_ADD, 63, 63);
    send_item(CMD_ADD, 5, 0);
    send_item(CMD_ADD, 42, 21);
    send_item(CMD_WALK, 63, 63);
    send_item(CMD_WALK, 0, 0);
    send_item(CMD_SPARE, 63, 63);
    send_item(CMD_WALK, 21, 0);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_WALK, 63, 0);

    // No vertex in use: every walk is an error and every edge is dropped.
    set_vertex_count(0);
    send_item(CMD_WALK, 0, 0);
    send_item(CMD_ADD, 0, 1);
    send_item(CMD_WALK, 63, 0);

    // A count beyond the vertex range behaves as the full range.
    set_vertex_count(127);
    send_item(CMD_ADD, 62, 63);
    send_item(CMD_ADD, 1, 62);
    send_item(CMD_WALK, 62, 0);

    // Count lowered below stored edges: they are still followed, while the
    // start and new endpoints are checked against the smaller count.
    set_vertex_count(1);
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, 0, 1);
    send_item(CMD_ADD, 63, 0);
    send_item(CMD_WALK, 0, 0);
    send_item(CMD_WALK, 1, 0);
    set_vertex_count(64);
    send_item(CMD_ADD, 0, 1);
    send_item(CMD_WALK, 1, 0);

    // Random phases over several counts, the extremes among them; one runs
    // with no idling on either side.
    random_phase(64, 30);
    random_phase(2, 25);
    steady = 1'b1;
    random_phase($urandom_range(3, 63), 30);
    steady = 1'b0;
    random_phase(1, 15);
    random_phase($urandom_range(3, 63), 30);

    // Fill the node memory until further edges are refused, then walk.
    set_vertex_count(64);
    send_item(CMD_CLEAR, 0, 0);
    for (int i = 0; i < 136; i++)
      send_item(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
    for (int i = 0; i < 8; i++)
      send_item(CMD_WALK, $urandom_range(0, 63), $urandom_range(0, 63));
    random_phase($urandom_range(3, 63), 30);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (visits_owed != 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && visits_owed == 0) begin
      $display("[graph_depth_first_walk_unit] OK");
    end else begin
      $display("[graph_depth_first_walk_unit] ERROR");
    end
    $finish;
  end

  // Guard against a block that stops answering.
  initial begin
    #15000000;
    $display("[graph_depth_first_walk_unit] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/gdfw_pkg.sv
hw/rtl/gdfw_ram.sv
hw/rtl/gdfw_head_table.sv
hw/rtl/graph_depth_first_walk_unit.sv
dv/graph_depth_first_walk_unit_checker.sv
dv/graph_depth_first_walk_unit_test.sv
